FILE: rtl/core/esf_pkg.sv
// Shared types and constants for the edge spring force block.
// Request and response payloads, opcodes, and controller-to-datapath command structs.
// No dependencies.
`default_nettype none

package esf_pkg;

  localparam int unsigned EDGE_COUNT_DEF   = 4096;
  localparam int unsigned VERTEX_COUNT_DEF = 1024;

  localparam int ITER_W = 7;

  localparam int SQ_STEPS   = 4;
  localparam int SQRT_STEPS = 34;
  localparam int DIV_STEPS  = 98;

  localparam logic [1:0] OP_CAPTURE = 2'd0;
  localparam logic [1:0] OP_APPLY   = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic [31:0] GAIN_RESET = 32'd65536;

  localparam logic [47:0] FORCE_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] FORCE_MIN = 48'h8000_0000_0000;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_CLEAR,
    PH_SQ,
    PH_SQRT,
    PH_CAPT,
    PH_PREP,
    PH_MUL1,
    PH_MUL2A,
    PH_MUL2B,
    PH_SUM,
    PH_DIV,
    PH_FIN,
    PH_RDA,
    PH_UPA,
    PH_RDB,
    PH_UPB,
    PH_RDR,
    PH_UPR,
    PH_RESP
  } esf_phase_e;

  typedef struct packed {
    esf_phase_e        phase;
    logic              load;
    logic [ITER_W-1:0] cnt;
    logic [1:0]        comp;
  } esf_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic len_zero;
  } esf_stat_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [11:0]        edge_index;
    logic [9:0]         vertex_a;
    logic [9:0]         vertex_b;
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] pos_a_z;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] pos_b_z;
  } esf_req_t;

  typedef struct packed {
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
    logic               degenerate;
    logic               saturated;
  } esf_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/esf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module esf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/esf_ctrl.sv
// Controller state machine for the edge spring force block.
// Sequences the datapath through its phases; depends on esf_pkg.
`default_nettype none

module esf_ctrl import esf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [1:0] opcode_i,
  input  wire esf_stat_t  stat_i,
  output esf_cmd_t        cmd_o,
  output logic            busy_o,
  output logic            done_o
);

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_SQ    = 5'd2;
  localparam logic [4:0] S_SQRT  = 5'd3;
  localparam logic [4:0] S_CAPT  = 5'd4;
  localparam logic [4:0] S_PREP  = 5'd5;
  localparam logic [4:0] S_MUL1  = 5'd6;
  localparam logic [4:0] S_MUL2A = 5'd7;
  localparam logic [4:0] S_MUL2B = 5'd8;
  localparam logic [4:0] S_SUM   = 5'd9;
  localparam logic [4:0] S_DIV   = 5'd10;
  localparam logic [4:0] S_FIN   = 5'd11;
  localparam logic [4:0] S_RDA   = 5'd12;
  localparam logic [4:0] S_UPA   = 5'd13;
  localparam logic [4:0] S_RDB   = 5'd14;
  localparam logic [4:0] S_UPB   = 5'd15;
  localparam logic [4:0] S_RDR   = 5'd16;
  localparam logic [4:0] S_UPR   = 5'd17;
  localparam logic [4:0] S_RESP  = 5'd18;

  logic [4:0]        state_q, state_d;
  logic [ITER_W-1:0] cnt_q, cnt_d;
  logic [1:0]        comp_q, comp_d;
  logic [1:0]        op_q, op_d;
  logic              load;

  assign load = (state_q == S_IDLE) && start_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    comp_d  = comp_q;
    op_d    = op_q;
    case (state_q)
      S_CLEAR: begin
        if (stat_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          op_d   = opcode_i;
          cnt_d  = '0;
          comp_d = '0;
          if (opcode_i == OP_READ) begin
            state_d = S_RDR;
          end else if (opcode_i == OP_CAPTURE || opcode_i == OP_APPLY) begin
            state_d = S_SQ;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SQ: begin
        if (cnt_q == ITER_W'(SQ_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_SQRT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_SQRT: begin
        if (cnt_q == ITER_W'(SQRT_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = (op_q == OP_CAPTURE) ? S_CAPT : S_PREP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_CAPT:  state_d = S_RESP;
      S_PREP:  state_d = stat_i.len_zero ? S_RESP : S_MUL1;
      S_MUL1:  state_d = S_MUL2A;
      S_MUL2A: state_d = S_MUL2B;
      S_MUL2B: state_d = S_SUM;
      S_SUM: begin
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (cnt_q == ITER_W'(DIV_STEPS - 1)) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_FIN: begin
        if (comp_q == 2'd2) begin
          state_d = S_RDA;
        end else begin
          comp_d  = comp_q + 1'b1;
          state_d = S_MUL1;
        end
      end
      S_RDA:  state_d = S_UPA;
      S_UPA:  state_d = S_RDB;
      S_RDB:  state_d = S_UPB;
      S_UPB:  state_d = S_RESP;
      S_RDR:  state_d = S_UPR;
      S_UPR:  state_d = S_RESP;
      S_RESP: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      comp_q  <= '0;
      op_q    <= OP_CAPTURE;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      comp_q  <= comp_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    cmd_o.load = load;
    cmd_o.cnt  = cnt_q;
    cmd_o.comp = comp_q;
    case (state_q)
      S_CLEAR: cmd_o.phase = PH_CLEAR;
      S_SQ:    cmd_o.phase = PH_SQ;
      S_SQRT:  cmd_o.phase = PH_SQRT;
      S_CAPT:  cmd_o.phase = PH_CAPT;
      S_PREP:  cmd_o.phase = PH_PREP;
      S_MUL1:  cmd_o.phase = PH_MUL1;
      S_MUL2A: cmd_o.phase = PH_MUL2A;
      S_MUL2B: cmd_o.phase = PH_MUL2B;
      S_SUM:   cmd_o.phase = PH_SUM;
      S_DIV:   cmd_o.phase = PH_DIV;
      S_FIN:   cmd_o.phase = PH_FIN;
      S_RDA:   cmd_o.phase = PH_RDA;
      S_UPA:   cmd_o.phase = PH_UPA;
      S_RDB:   cmd_o.phase = PH_RDB;
      S_UPB:   cmd_o.phase = PH_UPB;
      S_RDR:   cmd_o.phase = PH_RDR;
      S_UPR:   cmd_o.phase = PH_UPR;
      S_RESP:  cmd_o.phase = PH_RESP;
      default: cmd_o.phase = PH_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESP);

endmodule

`default_nettype wire

FILE: rtl/core/esf_dp.sv
// Datapath for the edge spring force block: shared multiplier, bit-serial
// square root and divider, saturating accumulators and the two RAMs.
// Depends on esf_pkg and esf_ram.
`default_nettype none

module esf_dp import esf_pkg::*; #(
  parameter int unsigned EDGE_COUNT   = EDGE_COUNT_DEF,
  parameter int unsigned VERTEX_COUNT = VERTEX_COUNT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire esf_cmd_t    cmd_i,
  output esf_stat_t        stat_o,
  input  wire esf_req_t    req_i,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_data_i,
  output esf_rsp_t         rsp_o
);

  localparam int unsigned EAW = (EDGE_COUNT > 1) ? $clog2(EDGE_COUNT) : 1;
  localparam int unsigned VAW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

  localparam logic signed [48:0] ACC_HI = 49'sd140737488355327;
  localparam logic signed [48:0] ACC_LO = -49'sd140737488355328;

  function automatic logic [48:0] sat_add(input logic signed [47:0] a,
                                          input logic signed [47:0] b);
    logic signed [48:0] s;
    logic [48:0]        r;
    s = 49'(a) + 49'(b);
    if (s > ACC_HI) begin
      r = {1'b1, FORCE_MAX};
    end else if (s < ACC_LO) begin
      r = {1'b1, FORCE_MIN};
    end else begin
      r = {1'b0, s[47:0]};
    end
    return r;
  endfunction

  // request and operand registers
  esf_req_t           req_q;
  logic [32:0]        d_mag_q [3];
  logic [2:0]         d_neg_q;
  logic [31:0]        gain_q;
  logic [VAW-1:0]     clr_q;

  // square root
  logic [67:0]        sum_q;
  logic [65:0]        prod_q;
  logic [36:0]        rem_q;
  logic [33:0]        root_q;

  // force computation
  logic [32:0]        mag_q;
  logic               diff_pos_q;
  logic [64:0]        p1_q;
  logic [65:0]        pa_q;
  logic [64:0]        pb_q;
  logic [97:0]        num_q;
  logic [48:0]        drem_q;

  // result
  logic signed [47:0] f_q [3];
  logic               deg_q;
  logic               sat_q;

  // RAM ports
  logic [31:0]        rl_rdata;
  logic [143:0]       vf_rdata;
  logic [143:0]       vf_wdata;
  logic [143:0]       acc_row;
  logic [VAW-1:0]     vf_addr;
  logic               vf_we;
  logic               vf_re;
  logic               rl_we;
  logic               rl_re;
  logic [31:0]        rl_wdata;

  logic               e_ok;
  logic               va_ok;
  logic               vb_ok;

  logic signed [31:0] pa_in [3];
  logic signed [31:0] pb_in [3];

  logic [1:0]         sel_idx;
  logic [32:0]        mag_sel;
  logic               neg_sel;
  logic [32:0]        mul_a;
  logic [32:0]        mul_b;
  logic [65:0]        mul_p;

  logic [36:0]        sq_rem2;
  logic [36:0]        sq_trial;
  logic               sq_ge;

  logic [49:0]        dv_rem2;
  logic [49:0]        dv_dvs;
  logic               dv_ge;
  logic [49:0]        dv_diff;

  logic [32:0]        len33;
  logic [32:0]        l0;

  logic               fin_ovf;
  logic [47:0]        fin_m;
  logic [47:0]        fin_val;

  logic [2:0]         acc_clip;

  assign e_ok  = 32'(req_q.edge_index) < EDGE_COUNT;
  assign va_ok = 32'(req_q.vertex_a) < VERTEX_COUNT;
  assign vb_ok = 32'(req_q.vertex_b) < VERTEX_COUNT;

  assign pa_in[0] = req_i.pos_a_x;
  assign pa_in[1] = req_i.pos_a_y;
  assign pa_in[2] = req_i.pos_a_z;
  assign pb_in[0] = req_i.pos_b_x;
  assign pb_in[1] = req_i.pos_b_y;
  assign pb_in[2] = req_i.pos_b_z;

  // component select: squares walk the counter, force steps walk the component
  assign sel_idx = (cmd_i.phase == PH_SQ) ? cmd_i.cnt[1:0] : cmd_i.comp;

  always_comb begin
    case (sel_idx)
      2'd0: begin mag_sel = d_mag_q[0]; neg_sel = d_neg_q[0]; end
      2'd1: begin mag_sel = d_mag_q[1]; neg_sel = d_neg_q[1]; end
      2'd2: begin mag_sel = d_mag_q[2]; neg_sel = d_neg_q[2]; end
      default: begin mag_sel = '0; neg_sel = 1'b0; end
    endcase
  end

  always_comb begin
    case (cmd_i.phase)
      PH_SQ:    begin mul_a = mag_sel;               mul_b = mag_sel; end
      PH_MUL1:  begin mul_a = {1'b0, gain_q};        mul_b = mag_sel; end
      PH_MUL2A: begin mul_a = p1_q[32:0];            mul_b = mag_q;   end
      PH_MUL2B: begin mul_a = {1'b0, p1_q[64:33]};   mul_b = mag_q;   end
      default:  begin mul_a = '0;                    mul_b = '0;      end
    endcase
  end

  assign mul_p = 66'(mul_a) * 66'(mul_b);

  // one root bit per cycle
  assign sq_rem2  = {rem_q[34:0], sum_q[67:66]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_ge    = sq_rem2 >= sq_trial;

  // one quotient bit per cycle; quotient shifts into the dividend register
  assign len33   = root_q[32:0];
  assign dv_rem2 = {drem_q, num_q[97]};
  assign dv_dvs  = {1'b0, len33, 16'b0};
  assign dv_ge   = dv_rem2 >= dv_dvs;
  assign dv_diff = dv_rem2 - dv_dvs;

  assign l0 = e_ok ? {1'b0, rl_rdata} : '0;

  assign fin_ovf = |num_q[97:47];
  assign fin_m   = fin_ovf ? FORCE_MAX : {1'b0, num_q[46:0]};
  assign fin_val = (diff_pos_q ^ neg_sel) ? (48'd0 - fin_m) : fin_m;

  always_comb begin
    logic [48:0]        r;
    logic signed [47:0] addend;
    for (int c = 0; c < 3; c++) begin
      addend = (cmd_i.phase == PH_UPA) ? (48'sd0 - f_q[c]) : f_q[c];
      r = sat_add(vf_rdata[48*c +: 48], addend);
      acc_row[48*c +: 48] = r[47:0];
      acc_clip[c] = r[48];
    end
  end

  always_comb begin
    case (cmd_i.phase)
      PH_CLEAR:      vf_addr = clr_q;
      PH_RDB, PH_UPB: vf_addr = VAW'(req_q.vertex_b);
      default:       vf_addr = VAW'(req_q.vertex_a);
    endcase
  end

  assign vf_re = (cmd_i.phase == PH_RDA) || (cmd_i.phase == PH_RDB) ||
                 (cmd_i.phase == PH_RDR);
  assign vf_we = (cmd_i.phase == PH_CLEAR) ||
                 ((cmd_i.phase == PH_UPA) && va_ok) ||
                 ((cmd_i.phase == PH_UPB) && vb_ok) ||
                 ((cmd_i.phase == PH_UPR) && va_ok);
  assign vf_wdata = ((cmd_i.phase == PH_UPA) || (cmd_i.phase == PH_UPB)) ? acc_row : '0;

  assign rl_re    = (cmd_i.phase == PH_SQ) && (cmd_i.cnt == '0);
  assign rl_we    = (cmd_i.phase == PH_CAPT) && e_ok;
  assign rl_wdata = root_q[32] ? 32'hFFFF_FFFF : root_q[31:0];

  esf_ram #(
    .WIDTH (32),
    .DEPTH (EDGE_COUNT)
  ) u_rest_ram (
    .clk_i   (clk_i),
    .we_i    (rl_we),
    .waddr_i (EAW'(req_q.edge_index)),
    .wdata_i (rl_wdata),
    .re_i    (rl_re),
    .raddr_i (EAW'(req_q.edge_index)),
    .rdata_o (rl_rdata)
  );

  esf_ram #(
    .WIDTH (144),
    .DEPTH (VERTEX_COUNT)
  ) u_force_ram (
    .clk_i   (clk_i),
    .we_i    (vf_we),
    .waddr_i (vf_addr),
    .wdata_i (vf_wdata),
    .re_i    (vf_re),
    .raddr_i (vf_addr),
    .rdata_o (vf_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
      clr_q  <= '0;
    end else begin
      if (cfg_we_i) gain_q <= cfg_data_i;
      if (cmd_i.phase == PH_CLEAR) clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      logic signed [32:0] dd;
      req_q  <= req_i;
      sum_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
      deg_q  <= 1'b0;
      sat_q  <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        dd = 33'(pb_in[c]) - 33'(pa_in[c]);
        d_neg_q[c] <= dd[32];
        d_mag_q[c] <= dd[32] ? (33'd0 - dd) : dd;
        f_q[c]     <= '0;
      end
    end else begin
      case (cmd_i.phase)
        PH_SQ: begin
          if (cmd_i.cnt != '0) sum_q <= sum_q + 68'(prod_q);
          if (cmd_i.cnt != ITER_W'(SQ_STEPS - 1)) prod_q <= mul_p;
        end
        PH_SQRT: begin
          sum_q  <= {sum_q[65:0], 2'b00};
          rem_q  <= sq_ge ? (sq_rem2 - sq_trial) : sq_rem2;
          root_q <= {root_q[32:0], sq_ge};
        end
        PH_CAPT: sat_q <= root_q[32];
        PH_PREP: begin
          if (root_q == '0) deg_q <= 1'b1;
          diff_pos_q <= len33 > l0;
          mag_q      <= (len33 >= l0) ? (len33 - l0) : (l0 - len33);
        end
        PH_MUL1:  p1_q <= mul_p[64:0];
        PH_MUL2A: pa_q <= mul_p;
        PH_MUL2B: pb_q <= mul_p[64:0];
        PH_SUM: begin
          num_q  <= 98'(pa_q) + {pb_q, 33'b0};
          drem_q <= '0;
        end
        PH_DIV: begin
          num_q  <= {num_q[96:0], dv_ge};
          drem_q <= dv_ge ? dv_diff[48:0] : dv_rem2[48:0];
        end
        PH_FIN: begin
          f_q[cmd_i.comp] <= fin_val;
          if (fin_ovf) sat_q <= 1'b1;
        end
        PH_UPA: if (va_ok && (|acc_clip)) sat_q <= 1'b1;
        PH_UPB: if (vb_ok && (|acc_clip)) sat_q <= 1'b1;
        PH_UPR: begin
          if (va_ok) begin
            for (int c = 0; c < 3; c++) f_q[c] <= vf_rdata[48*c +: 48];
          end
        end
        default: ;
      endcase
    end
  end

  assign stat_o.clear_last = (clr_q == VAW'(VERTEX_COUNT - 1));
  assign stat_o.len_zero   = (root_q == '0);

  assign rsp_o.force_x    = f_q[0];
  assign rsp_o.force_y    = f_q[1];
  assign rsp_o.force_z    = f_q[2];
  assign rsp_o.degenerate = deg_q;
  assign rsp_o.saturated  = sat_q;

endmodule

`default_nettype wire

FILE: rtl/core/edge_spring_force.sv
// Edge spring force block, top level. One request at a time; done_o strobes the
// response for one cycle. Captures and spring applies run a bit-serial 34-step square
// root, and a spring apply on a nonzero-length edge adds three 98-step divisions.
// After reset the force RAM is swept to zero while busy is high. The receiver
// cannot stall.
// Depends on esf_pkg, esf_ctrl, esf_dp and esf_ram.
`default_nettype none

module edge_spring_force import esf_pkg::*; #(
  parameter int unsigned EDGE_COUNT   = EDGE_COUNT_DEF,
  parameter int unsigned VERTEX_COUNT = VERTEX_COUNT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire esf_req_t    req_i,
  output logic             done_o,
  output esf_rsp_t         rsp_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i
);

  esf_cmd_t  cmd;
  esf_stat_t stat;

  assign cfg_ready_o = 1'b1;

  esf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (req_i.opcode),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  esf_dp #(
    .EDGE_COUNT   (EDGE_COUNT),
    .VERTEX_COUNT (VERTEX_COUNT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .req_i      (req_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .rsp_o      (rsp_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("response strobe longer than one cycle");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("response while idle");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.degenerate) |->
      (rsp_o.force_x == 48'sd0 && rsp_o.force_y == 48'sd0 && rsp_o.force_z == 48'sd0 &&
       !rsp_o.saturated))
    else $error("degenerate edge reported a force");

endmodule

`default_nettype wire

FILE: tb/edge_spring_force_tb.sv
// Self-checking testbench for edge_spring_force: spring applies, rest length captures,
// force reads and unused opcodes against an internal fixed-point predictor.
// Depends on esf_pkg and the edge_spring_force RTL.
`default_nettype none

module edge_spring_force_tb;
  import esf_pkg::*;

  localparam int  WATCHDOG_LIMIT = 6000;
  localparam int  DRAIN_CYCLES   = 400;
  localparam int  PHASE_ITEMS    = 305;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam longint F_HI = 64'sd140737488355327;
  localparam longint F_LO = -64'sd140737488355328;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  esf_req_t    req_i = '0;
  logic        done_o;
  esf_rsp_t    rsp_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  edge_spring_force u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state
  logic [31:0] gain_model = GAIN_RESET;
  logic [31:0] rest_len[4096];
  longint      force_acc[1024][3];

  esf_req_t    request_q[$];
  esf_rsp_t    expected_rsp_q[$];
  int          captured_edges[$];
  int          error_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          idle_cycles = 0;

  function automatic logic [33:0] floor_sqrt(input logic [67:0] s);
    logic [33:0] r;
    logic [33:0] c;
    logic [69:0] cc;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c  = r | (34'd1 << b);
      cc = 70'(c) * 70'(c);
      if (cc <= 70'(s)) r = c;
    end
    return r;
  endfunction

  // Add to a vertex accumulator with clipping; return 1 when clipped.
  function automatic bit add_force(input int v, input int c, input longint delta);
    longint s;
    s = force_acc[v][c] + delta;
    if (s > F_HI) begin
      force_acc[v][c] = F_HI;
      return 1'b1;
    end
    if (s < F_LO) begin
      force_acc[v][c] = F_LO;
      return 1'b1;
    end
    force_acc[v][c] = s;
    return 1'b0;
  endfunction

  function automatic esf_rsp_t spring_response(input esf_req_t r);
    esf_rsp_t     o;
    longint       d[3];
    longint       f[3];
    logic [67:0]  sq_sum;
    logic [33:0]  len;
    logic [63:0]  ad;
    longint       diff;
    logic [63:0]  mag;
    logic [127:0] num;
    logic [127:0] q;
    longint       m;
    bit           sat;
    o = '0;
    sat = 1'b0;
    if (r.opcode == OP_UNUSED) return o;
    if (r.opcode == OP_READ) begin
      o.force_x = force_acc[r.vertex_a][0][47:0];
      o.force_y = force_acc[r.vertex_a][1][47:0];
      o.force_z = force_acc[r.vertex_a][2][47:0];
      for (int i = 0; i < 3; i++) force_acc[r.vertex_a][i] = 0;
      return o;
    end
    d[0] = longint'(r.pos_b_x) - longint'(r.pos_a_x);
    d[1] = longint'(r.pos_b_y) - longint'(r.pos_a_y);
    d[2] = longint'(r.pos_b_z) - longint'(r.pos_a_z);
    sq_sum = '0;
    for (int i = 0; i < 3; i++) begin
      ad = (d[i] < 0) ? 64'(-d[i]) : 64'(d[i]);
      sq_sum += 68'(ad) * 68'(ad);
    end
    len = floor_sqrt(sq_sum);
    if (r.opcode == OP_CAPTURE) begin
      if (len > 34'hFFFF_FFFF) begin
        rest_len[r.edge_index] = 32'hFFFF_FFFF;
        o.saturated = 1'b1;
      end else begin
        rest_len[r.edge_index] = len[31:0];
      end
      return o;
    end
    if (len == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    diff = longint'(len) - longint'(rest_len[r.edge_index]);
    mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
    for (int i = 0; i < 3; i++) begin
      ad  = (d[i] < 0) ? 64'(-d[i]) : 64'(d[i]);
      num = 128'(gain_model) * 128'(ad) * 128'(mag);
      q   = num / (128'(len) << 16);
      if (q > 128'(F_HI)) begin
        m = F_HI;
        sat = 1'b1;
      end else begin
        m = longint'(q[63:0]);
      end
      f[i] = ((diff > 0) != (d[i] < 0)) ? -m : m;
    end
    for (int i = 0; i < 3; i++) begin
      if (add_force(r.vertex_a, i, -f[i])) sat = 1'b1;
      if (add_force(r.vertex_b, i, f[i])) sat = 1'b1;
    end
    o.force_x = f[0][47:0];
    o.force_y = f[1][47:0];
    o.force_z = f[2][47:0];
    o.saturated = sat;
    return o;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  // Driver: bursts of requests with random gaps between them.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        expected_rsp_q.insert(expected_rsp_q.size(), spring_response(req_i));
      if (start && busy) begin
        // hold the request until the block takes it
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (request_q.size() > 0) begin
        start <= 1'b1;
        req_i <= request_q.pop_front();
        if (burst_left == 0) begin
          burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 8);
          gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: results come one cycle wide and cannot be held off.
  always @(posedge clk_i) begin
    esf_rsp_t want;
    if (rst_ni && done_o) begin
      if (expected_rsp_q.size() == 0) begin
        report_mismatch("unexpected response", 1, 0);
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp_o.force_x !== want.force_x)
          report_mismatch("force_x", rsp_o.force_x, want.force_x);
        if (rsp_o.force_y !== want.force_y)
          report_mismatch("force_y", rsp_o.force_y, want.force_y);
        if (rsp_o.force_z !== want.force_z)
          report_mismatch("force_z", rsp_o.force_z, want.force_z);
        if (rsp_o.degenerate !== want.degenerate)
          report_mismatch("degenerate", rsp_o.degenerate, want.degenerate);
        if (rsp_o.saturated !== want.saturated)
          report_mismatch("saturated", rsp_o.saturated, want.saturated);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($urandom_range(0, 2 ** 21)) - 32'(2 ** 20);
    endcase
  endfunction

  function automatic logic [9:0] pick_vertex();
    if ($urandom_range(0, 3) == 0) return 10'($urandom_range(0, 1023));
    if ($urandom_range(0, 15) == 0) return 10'd1023;
    return 10'($urandom_range(0, 7));
  endfunction

  function automatic esf_req_t make_request(input logic [1:0] op, input int e,
                                            input int va, input int vb);
    esf_req_t r;
    r = '0;
    r.opcode = op;
    r.edge_index = 12'(e);
    r.vertex_a = 10'(va);
    r.vertex_b = 10'(vb);
    return r;
  endfunction

  // Random request; applies use a captured edge, and half of them nudge pos_b close to pos_a.
  function automatic esf_req_t random_request();
    esf_req_t r;
    int       pick;
    r = '0;
    r.vertex_a = pick_vertex();
    r.vertex_b = pick_vertex();
    r.pos_a_x = rand_pos();
    r.pos_a_y = rand_pos();
    r.pos_a_z = rand_pos();
    r.pos_b_x = rand_pos();
    r.pos_b_y = rand_pos();
    r.pos_b_z = rand_pos();
    pick = $urandom_range(0, 99);
    if (pick < 20 || captured_edges.size() == 0) begin
      r.opcode = OP_CAPTURE;
      r.edge_index = $urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 15));
      captured_edges.insert(captured_edges.size(), int'(r.edge_index));
    end else if (pick < 70) begin
      r.opcode = OP_APPLY;
      r.edge_index = 12'(captured_edges[$urandom_range(0, captured_edges.size() - 1)]);
      if ($urandom_range(0, 1)) begin
        r.pos_b_x = r.pos_a_x + 32'($urandom_range(0, 2 ** 18)) - 32'(2 ** 17);
        r.pos_b_y = r.pos_a_y + 32'($urandom_range(0, 2 ** 18)) - 32'(2 ** 17);
        r.pos_b_z = r.pos_a_z + 32'($urandom_range(0, 2 ** 18)) - 32'(2 ** 17);
      end
      if ($urandom_range(0, 19) == 0) begin
        r.pos_b_x = r.pos_a_x;
        r.pos_b_y = r.pos_a_y;
        r.pos_b_z = r.pos_a_z;
      end
    end else if (pick < 96) begin
      r.opcode = OP_READ;
      r.edge_index = 12'($urandom);
    end else begin
      r.opcode = OP_UNUSED;
      r.edge_index = 12'($urandom);
    end
    return r;
  endfunction

  task automatic add_request(input esf_req_t r);
    request_q.insert(request_q.size(), r);
  endtask

  task automatic wait_drained();
    while (request_q.size() > 0 || expected_rsp_q.size() > 0 || start || busy)
      @(posedge clk_i);
  endtask

  task automatic write_gain(input logic [31:0] value);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    gain_model = value;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    esf_req_t    r;
    logic [31:0] gains[4];
    for (int v = 0; v < 1024; v++)
      for (int c = 0; c < 3; c++) force_acc[v][c] = 0;
    gains[0] = 32'd0;
    gains[1] = 32'hFFFF_FFFF;
    gains[2] = $urandom;
    gains[3] = 32'd3 << 16;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: rest length that clips, short edge, degenerate and same-vertex applies.
    r = make_request(OP_CAPTURE, 0, 1023, 0);
    r.pos_a_x = 32'h8000_0000; r.pos_a_y = 32'h8000_0000; r.pos_a_z = 32'h8000_0000;
    r.pos_b_x = 32'h7FFF_FFFF; r.pos_b_y = 32'h7FFF_FFFF; r.pos_b_z = 32'h7FFF_FFFF;
    add_request(r);
    r = make_request(OP_CAPTURE, 4095, 0, 1023);
    r.pos_b_x = 32'h0001_0000;
    add_request(r);
    r = make_request(OP_APPLY, 4095, 0, 1023);
    r.pos_b_x = 32'h0002_0000;
    add_request(r);
    r.pos_b_x = 32'hFFFE_0000;
    r.pos_a_y = 32'h0003_0000;
    add_request(r);
    r = make_request(OP_APPLY, 4095, 3, 4);
    r.pos_a_x = 32'h1234_5678; r.pos_b_x = 32'h1234_5678;
    add_request(r);
    r = make_request(OP_APPLY, 0, 5, 5);
    r.pos_a_x = 32'h7FFF_FFFF; r.pos_b_x = 32'h8000_0000;
    r.pos_a_y = 32'h7FFF_FFFF; r.pos_b_y = 32'h8000_0000;
    add_request(r);
    r = make_request(OP_APPLY, 4095, 1, 2);
    r.pos_a_x = 32'h8000_0000; r.pos_a_y = 32'h8000_0000; r.pos_a_z = 32'h8000_0000;
    r.pos_b_x = 32'h7FFF_FFFF; r.pos_b_y = 32'h7FFF_FFFF; r.pos_b_z = 32'h7FFF_FFFF;
    repeat (3) add_request(r);
    add_request(make_request(OP_READ, 0, 0, 0));
    add_request(make_request(OP_READ, 4095, 1023, 1023));
    add_request(make_request(OP_READ, 0, 5, 0));
    add_request(make_request(OP_READ, 0, 1, 0));
    add_request(make_request(OP_READ, 0, 2, 0));
    add_request(make_request(OP_READ, 0, 1, 0));
    r = make_request(OP_UNUSED, 4095, 1023, 1023);
    r.pos_a_x = '1; r.pos_a_y = '1; r.pos_a_z = '1;
    r.pos_b_x = '1; r.pos_b_y = '1; r.pos_b_z = '1;
    add_request(r);
    captured_edges.insert(captured_edges.size(), 0);
    captured_edges.insert(captured_edges.size(), 4095);
    for (int i = 0; i < PHASE_ITEMS; i++) add_request(random_request());

    foreach (gains[p]) begin
      write_gain(gains[p]);
      // Large gains overflow on small edges; drive them hard once
      if (p == 1) begin
        r = make_request(OP_APPLY, 0, 6, 7);
        r.pos_b_x = 32'h0000_0001;
        add_request(r);
        r = make_request(OP_APPLY, 4095, 6, 7);
        r.pos_a_x = 32'h8000_0000; r.pos_b_x = 32'h7FFF_FFFF;
        repeat (2) add_request(r);
        add_request(make_request(OP_READ, 0, 7, 0));
      end
      for (int i = 0; i < PHASE_ITEMS; i++) add_request(random_request());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
